### rtl/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared constants, round tables and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned BlockBits  = 512;
  localparam int unsigned NumRounds  = 64;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam logic [5:0]  LengthPos  = 6'd56;
  localparam logic [5:0]  LastByte   = 6'd63;
  localparam logic [5:0]  LastRound  = 6'd63;

  // Control requests from the sequencer to the round unit.
  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       start;
    logic       step;
  } s256_ctl_t;

  typedef logic [WordBits-1:0] s256_word_t;

  // Rotate right by a constant amount.
  function automatic s256_word_t ror32(input s256_word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (WordBits - n));
  endfunction

  // Round constants of the compression function.
  function automatic s256_word_t round_k(input logic [5:0] idx);
    unique case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h00000000;
    endcase
  endfunction

  // Initial hash value, word by word.
  function automatic s256_word_t init_h(input logic [2:0] idx);
    unique case (idx)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      3'd7: init_h = 32'h5be0cd19;
      default: init_h = 32'h00000000;
    endcase
  endfunction

endpackage

### rtl/s256_if.sv
// ----------------------------------------------------------------------------
// s256_if
// Valid/ready channel interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------

// Message channel: one optional byte and an end mark per request.
interface s256_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

// Digest channel: one 32-bit digest word per request.
interface s256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

### rtl/s256_core.sv
// ----------------------------------------------------------------------------
// s256_core
// Block register, message schedule and one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
module s256_core (
  input  logic                 clk,
  input  logic                 rst,
  input  s256_pkg::s256_ctl_t  ctl,
  input  s256_pkg::s256_word_t hash [s256_pkg::NumWords],
  output s256_pkg::s256_word_t work [s256_pkg::NumWords],
  output logic                 round_last
);

  logic [s256_pkg::BlockBits-1:0] window;
  s256_pkg::s256_word_t           va [s256_pkg::NumWords];
  logic [5:0]                     rnd;

  s256_pkg::s256_word_t w0, w1, w9, w14, w_new;
  s256_pkg::s256_word_t sig0, sig1, big0, big1, ch, maj, t1, t2;

  // The four schedule taps sit at fixed places in the window.
  assign w0  = window[511:480];
  assign w1  = window[479:448];
  assign w9  = window[223:192];
  assign w14 = window[63:32];

  // Next schedule word.
  always_comb begin
    sig0  = s256_pkg::ror32(w1, 7) ^ s256_pkg::ror32(w1, 18) ^ (w1 >> 3);
    sig1  = s256_pkg::ror32(w14, 17) ^ s256_pkg::ror32(w14, 19) ^ (w14 >> 10);
    w_new = w0 + sig0 + w9 + sig1;
  end

  // One compression round on the working variables.
  always_comb begin
    big1 = s256_pkg::ror32(va[4], 6) ^ s256_pkg::ror32(va[4], 11)
         ^ s256_pkg::ror32(va[4], 25);
    ch   = (va[4] & va[5]) ^ (~va[4] & va[6]);
    t1   = va[7] + big1 + ch + s256_pkg::round_k(rnd) + w0;
    big0 = s256_pkg::ror32(va[0], 2) ^ s256_pkg::ror32(va[0], 13)
         ^ s256_pkg::ror32(va[0], 22);
    maj  = (va[0] & va[1]) ^ (va[0] & va[2]) ^ (va[1] & va[2]);
    t2   = big0 + maj;
  end

  assign round_last = ctl.step && (rnd == s256_pkg::LastRound);
  assign work       = va;

  // Round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (ctl.start) begin
      rnd <= '0;
    end else if (ctl.step) begin
      rnd <= rnd + 6'd1;
    end
  end

  // Block bytes shift in; during rounds the window advances by one word.
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      window <= {window[s256_pkg::BlockBits-9:0], ctl.shift_byte};
    end else if (ctl.step) begin
      window <= {window[s256_pkg::BlockBits-33:0], w_new};
    end
  end

  // Working variables: loaded from the chaining value, then one round a cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      va <= hash;
    end else if (ctl.step) begin
      va[7] <= va[6];
      va[6] <= va[5];
      va[5] <= va[4];
      va[4] <= va[3] + t1;
      va[3] <= va[2];
      va[2] <= va[1];
      va[1] <= va[0];
      va[0] <= t1 + t2;
    end
  end

endmodule

### rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream, with padding and digest output in hardware.
// ----------------------------------------------------------------------------
// Each request carries at most one message byte and may close the message.
// A byte is taken when its request is accepted; when it completes a 64-byte
// block the block is compressed by a single round unit and the result is then
// folded into the chaining value. Closing a message writes the marker, zero
// padding and the length one byte per cycle, spilling into a second block when
// the length does not fit, runs one or two compressions, then presents eight
// digest words, one per cycle while the sink is ready. The block does not take
// requests while it compresses, pads or emits; afterwards it restarts from the
// initial hash value, so an end mark with no byte yields the digest of the
// empty message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic       clk,
  input  logic       rst,
  s256_msg_if.sink   msg,
  s256_dig_if.source digest
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                state, state_next;
  s256_pkg::s256_ctl_t   ctl;
  s256_pkg::s256_word_t  hash [s256_pkg::NumWords];
  s256_pkg::s256_word_t  work [s256_pkg::NumWords];
  logic                  round_last;

  logic [5:0]  fill;
  logic [63:0] total;
  logic        padding;
  logic        mark_done;
  logic        final_blk;
  logic [2:0]  emit_idx;

  logic        accept;
  logic        block_full;
  logic        emit_load;
  logic [7:0]  pad_byte;
  logic [63:0] len_shifted;

  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;
  logic        out_valid;

  assign accept = msg.valid && msg.ready;
  assign msg.ready = (state == ST_IDLE);

  // Padding byte: marker first, then zeros, with the bit length at the end
  // of the final block.
  assign len_shifted = {total[60:0], 3'b000} << {fill[2:0], 3'b000};
  always_comb begin
    if (!mark_done) begin
      pad_byte = s256_pkg::PadMark;
    end else if (final_blk && (fill >= s256_pkg::LengthPos)) begin
      pad_byte = len_shifted[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Requests to the round unit.
  always_comb begin
    ctl.shift_en   = (accept && msg.has_byte) || (state == ST_PAD);
    ctl.shift_byte = (state == ST_PAD) ? pad_byte : msg.data_byte;
    block_full     = ctl.shift_en && (fill == s256_pkg::LastByte);
    ctl.start      = block_full;
    ctl.step       = (state == ST_ROUND);
  end

  assign emit_load = (state == ST_EMIT) && (!out_valid || digest.ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (block_full) begin
            state_next = ST_ROUND;
          end else if (msg.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (final_blk) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (emit_load && (emit_idx == 3'd7)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count, byte total and padding flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      total     <= '0;
      padding   <= 1'b0;
      mark_done <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      if (ctl.shift_en) begin
        fill <= fill + 6'd1;
      end
      if (accept && msg.has_byte) begin
        total <= total + 64'd1;
      end
      if (accept && msg.end_of_message) begin
        padding <= 1'b1;
      end
      if ((state == ST_PAD) && !mark_done) begin
        mark_done <= 1'b1;
        final_blk <= (fill < s256_pkg::LengthPos);
      end
      if ((state == ST_FOLD) && padding) begin
        final_blk <= 1'b1;
      end
      if (emit_load && (emit_idx == 3'd7)) begin
        fill      <= '0;
        total     <= '0;
        padding   <= 1'b0;
        mark_done <= 1'b0;
        final_blk <= 1'b0;
      end
    end
  end

  // Chaining value: fold after each block, shift out and reload during emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < s256_pkg::NumWords; i++) begin
        hash[i] <= s256_pkg::init_h(3'(i));
      end
    end else if (state == ST_FOLD) begin
      for (int i = 0; i < s256_pkg::NumWords; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end else if (emit_load) begin
      for (int i = 0; i < s256_pkg::NumWords - 1; i++) begin
        hash[i] <= hash[i+1];
      end
      hash[s256_pkg::NumWords-1] <= s256_pkg::init_h(emit_idx);
    end
  end

  // Emit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (emit_load) begin
      emit_idx <= emit_idx + 3'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word  <= hash[0];
      out_index <= emit_idx;
      out_last  <= (emit_idx == 3'd7);
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

  s256_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .hash       (hash),
    .work       (work),
    .round_last (round_last)
  );

endmodule

### rtl/s256_checker.sv
// ----------------------------------------------------------------------------
// s256_checker
// Port-level checks on the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
module s256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        has_byte,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // The final word flag marks exactly the eighth word.
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // While a digest is only partly delivered, no new request is taken.
  a_busy_mid_digest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (word_index != 3'd7)) |-> !in_ready)
    else $error("request accepted in the middle of a digest");

  // A request with neither a byte nor an end mark leaves the block ready.
  a_empty_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !has_byte && !end_of_message) |=> in_ready)
    else $error("empty request made the block busy");

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)
                                   && $stable(word_index)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher s256_checker u_s256_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (msg.valid),
  .in_ready       (msg.ready),
  .has_byte       (msg.has_byte),
  .end_of_message (msg.end_of_message),
  .out_valid      (digest.valid),
  .out_ready      (digest.ready),
  .digest_word    (digest.digest_word),
  .word_index     (digest.word_index),
  .last_word      (digest.last_word)
);

### test/sha256_stream_hasher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the message and digest channels of the SHA-256 stream hasher,
// predicts every digest word from the accepted message requests and compares
// each digest request with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic   clk,
  input  logic   rst,
  s256_msg_if    msg,
  s256_dig_if    digest,
  output int     fail_count,
  output int     pending
);

  localparam int unsigned BlockSize    = 64;
  localparam int unsigned LengthOffset = 56;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [7:0]  MarkByte     = 8'h80;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartValue [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Predicted hasher state.
  logic [31:0]  hash_value [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill_level;
  logic [63:0]  message_bytes;

  // Digest words predicted but not yet seen on the output.
  digest_word_t digest_queue [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_value[i] = StartValue[i];
    fill_level    = 0;
    message_bytes = '0;
  endfunction

  // Runs the 64 rounds over the current block and folds the result in.
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                  block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    a = hash_value[0]; b = hash_value[1]; c = hash_value[2]; d = hash_value[3];
    e = hash_value[4]; f = hash_value[5]; g = hash_value[6]; h = hash_value[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[i] + sched[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_value[0] += a; hash_value[1] += b; hash_value[2] += c; hash_value[3] += d;
    hash_value[4] += e; hash_value[5] += f; hash_value[6] += g; hash_value[7] += h;
  endfunction

  // Takes one accepted message request and queues any digest it completes.
  function automatic void absorb_request(input logic [7:0] data, input logic has_data,
                                         input logic closes);
    logic [63:0]  bit_length;
    digest_word_t word;
    if (has_data) begin
      block_bytes[fill_level] = data;
      fill_level++;
      message_bytes++;
      if (fill_level == BlockSize) begin
        compress_block();
        fill_level = 0;
      end
    end
    if (closes) begin
      bit_length = message_bytes << 3;
      block_bytes[fill_level] = MarkByte;
      fill_level++;
      // The length does not fit behind the marker, so it needs a block of its own.
      if (fill_level > LengthOffset) begin
        while (fill_level < BlockSize) begin
          block_bytes[fill_level] = 8'h00;
          fill_level++;
        end
        compress_block();
        fill_level = 0;
      end
      while (fill_level < LengthOffset) begin
        block_bytes[fill_level] = 8'h00;
        fill_level++;
      end
      for (int i = 0; i < 8; i++) block_bytes[LengthOffset + i] = bit_length[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        word.word  = hash_value[i];
        word.index = 3'(i);
        word.last  = (i == 7);
        digest_queue.insert(digest_queue.size(), word);
      end
      restart_message();
    end
  endfunction

  // Prediction and comparison, sampled at the rising edge.
  always @(posedge clk) begin
    digest_word_t want;
    digest_word_t seen;
    if (rst) begin
      restart_message();
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (msg.valid && msg.ready) begin
        absorb_request(msg.data_byte, msg.has_byte, msg.end_of_message);
      end
      if (digest.valid && digest.ready) begin
        seen = '{digest.digest_word, digest.word_index, digest.last_word};
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("%0t: digest request with none expected: word %h index %0d last %0b",
                     $realtime, seen.word, seen.index, seen.last);
          end
        end else begin
          want = digest_queue.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display("%0t: digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                       $realtime, want.word, want.index, want.last,
                       seen.word, seen.index, seen.last);
            end
          end
        end
      end
    end
    pending = digest_queue.size();
  end

endmodule

### test/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Drives byte streams into the SHA-256 stream hasher and reports the verdict.
// Directed messages cover empty input, end marks with and without a byte and
// the byte extremes; random messages follow, with lengths biased towards the
// padding and block boundaries, under several idling patterns on both sides
// and one long hold-off of the digest receiver.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

  localparam int  ItemTarget  = 450;
  localparam int  HoldCycles  = 500;
  localparam int  DrainLimit  = 20000;
  localparam int  SettleCycles = 300;
  localparam time TimeLimit   = 5_000_000;

  typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idling_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;
  bit   pressure_go = 1'b0;
  int   source_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   item_count = 0;
  int   fail_count;
  int   pending;

  s256_msg_if msg_ch ();
  s256_dig_if dig_ch ();

  sha256_stream_hasher i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  sha256_digest_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg_ch),
    .digest     (dig_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Digest receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Long receiver hold-off, so that the hasher backs up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Overall limit on the run.
  initial begin
    #(TimeLimit);
    $display("sha256_stream_hasher test failed");
    $finish;
  end

  function automatic void set_idling(input idling_t mode);
    source_idle_pct = (mode == IDLE_SOURCE) ? 86 : (mode == IDLE_BOTH) ? 17 : 0;
    sink_stall_pct  = (mode == IDLE_SINK)   ? 86 : (mode == IDLE_BOTH) ? 17 : 0;
  endfunction

  // Offers one message request and returns once it has been accepted.
  task automatic send_request(input logic [7:0] data, input logic has_data,
                              input logic closes);
    logic taken;
    while ($urandom_range(99) < source_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= data;
    msg_ch.has_byte       <= has_data;
    msg_ch.end_of_message <= closes;
    // Ready is stable from the falling edge until the next rising edge.
    do begin
      @(negedge clk);
      taken = msg_ch.ready;
      @(posedge clk);
    end while (!taken);
    if (has_data || closes) item_count++;
  endtask

  // One message of random bytes, with occasional empty requests mixed in.
  task automatic send_message(input int length);
    logic closing;
    for (int k = 0; k < length; k++) begin
      if ($urandom_range(99) < 8) send_request(8'($urandom), 1'b0, 1'b0);
      closing = (k == length - 1) && ($urandom_range(1) == 1);
      send_request(8'($urandom), 1'b1, closing);
      if (closing) return;
    end
    send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int       boundary [10];
    int       length;
    int       pick;
    int       drain;
    idling_t  mode;

    boundary              = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    rst                   <= 1'b1;
    msg_ch.valid          <= 1'b0;
    msg_ch.data_byte      <= 8'h00;
    msg_ch.has_byte       <= 1'b0;
    msg_ch.end_of_message <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: an ignored request, the empty message, a byte carrying the end
    // mark, the byte extremes and an end mark arriving on its own.
    set_idling(IDLE_NONE);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request("a", 1'b1, 1'b0);
    send_request("b", 1'b1, 1'b0);
    send_request("c", 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);

    // Random messages; the receiver holds off early in the unthrottled phase.
    pressure_go = 1'b1;
    while (item_count < ItemTarget) begin
      mode = idling_t'((item_count * 4) / ItemTarget);
      set_idling(mode);
      pick = $urandom_range(99);
      if (pick < 60) begin
        length = $urandom_range(20);
      end else if (pick < 80) begin
        length = boundary[$urandom_range(9)];
      end else begin
        length = $urandom_range(130, 21);
      end
      send_message(length);
    end
    msg_ch.valid <= 1'b0;

    // Let the checker count the last request before looking at its backlog.
    @(posedge clk);

    // Wait for the outstanding digests, then let the hasher settle.
    drain = 0;
    while (pending != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("sha256_stream_hasher test passed");
    end else begin
      $display("sha256_stream_hasher test failed");
    end
    $finish;
  end

endmodule
